// ----- hw/rtl/bol_pkg.sv -----
// Shared constants and types for the bounded ordered list core.
`timescale 1ns / 1ps
package bol_pkg;

   localparam int CAPACITY   = 16;
   localparam int DATA_WIDTH = 32;
   localparam int VALUE_W    = 32;
   localparam int CNT_W      = $clog2(CAPACITY + 1);
   localparam int LIMIT_W    = 5;
   localparam int CMP_W      = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

   localparam logic [1:0] OP_INSERT  = 2'd0;
   localparam logic [1:0] OP_DELETE  = 2'd1;
   localparam logic [1:0] OP_REVERSE = 2'd2;

   // Per-cycle command broadcast to every cell.
   typedef struct packed {
      logic load_tail;  // write the item into the tail slot
      logic push_head;  // every cell takes its head-side neighbor
      logic del_fwd;    // delete, list stored head first
      logic del_rev;    // delete, list stored tail first
      logic any_match;  // some valid cell matched
   } cell_ctrl_type;

endpackage

// ----- hw/rtl/bol_cell.sv -----
// One storage cell of the list: holds an entry, compares it, moves it to a neighbor.
`timescale 1ns / 1ps
module bol_cell (
   input  logic                             clock,
   input  bol_pkg::cell_ctrl_type           ctrl,
   input  logic                             entry_valid,
   input  logic                             tail_slot,
   input  logic [bol_pkg::DATA_WIDTH-1:0]   req_word,
   input  logic [bol_pkg::DATA_WIDTH-1:0]   left_word,
   input  logic [bol_pkg::DATA_WIDTH-1:0]   right_word,
   input  logic                             pre_in,
   input  logic                             suf_in,
   output logic                             pre_out,
   output logic                             suf_out,
   output logic [bol_pkg::DATA_WIDTH-1:0]   word
);
   import bol_pkg::*;

   logic [DATA_WIDTH-1:0] word_ff;
   logic [DATA_WIDTH-1:0] word_in;
   logic                  match;
   logic                  shift_up;

   assign match   = entry_valid && (word_ff == req_word);
   assign pre_out = pre_in | match;
   assign suf_out = suf_in | match;
   assign word    = word_ff;

   // Close the gap: this cell and all behind the removed entry take the next one.
   assign shift_up = (ctrl.del_fwd && pre_out) ||
                     (ctrl.del_rev && ctrl.any_match && !suf_in);

   always_comb begin
      word_in = word_ff;
      if (ctrl.load_tail && tail_slot) begin
         word_in = req_word;
      end else if (ctrl.push_head) begin
         word_in = left_word;
      end else if (shift_up) begin
         word_in = right_word;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

endmodule

// ----- hw/rtl/bounded_ordered_list_core.sv -----
// Top level: bounded ordered list built from a row of storage cells.
// The result item is registered and is on the rsp_ ports in the cycle after start is taken.
// Throughput: one item per cycle while not busy; every operation takes one pass of the cells.
// busy is high while reset is held and clears at the first clock edge that samples reset low.
// Results are shown for one cycle under rsp_strobe; the receiver cannot stall them.
// Reset clears the count, the orientation bit and the limit (back to 16); entries are not cleared.
`timescale 1ns / 1ps
module bounded_ordered_list_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [1:0]                    req_operation,
   input  logic signed [bol_pkg::VALUE_W-1:0] req_value,
   output logic                          rsp_strobe,
   output logic                          rsp_succeeded,
   output logic [4:0]                    rsp_entry_count,
   output logic                          rsp_full_flag,
   output logic                          rsp_empty_flag,
   input  logic                          csr_write_enable,
   input  logic [bol_pkg::LIMIT_W-1:0]   csr_write_data
);
   import bol_pkg::*;

   // Control state
   logic [CNT_W-1:0]   count_ff,   count_in;
   logic               flipped_ff, flipped_in;
   logic [LIMIT_W-1:0] limit_ff;
   logic               busy_ff;

   // Result registers
   logic               strobe_ff;
   logic               ok_ff, ok_in;
   logic [4:0]         cnt_out_ff;
   logic               full_ff, full_in;
   logic               empty_ff;

   logic               accept;
   logic [CMP_W-1:0]   active_limit;
   logic [CMP_W-1:0]   count_now;
   logic [CMP_W-1:0]   count_next;
   logic               has_room;
   logic [DATA_WIDTH-1:0] req_word;
   cell_ctrl_type      ctrl;

   // Chains between neighbors: head-side prefix of matches, tail-side suffix.
   logic                  pre_c  [0:CAPACITY];
   logic                  suf_c  [0:CAPACITY];
   logic [DATA_WIDTH-1:0] word_c [0:CAPACITY-1];

   assign accept   = start && !busy_ff;
   assign busy     = busy_ff;
   assign req_word = req_value[DATA_WIDTH-1:0];

   // The limit in force is the smaller of the register and the cell count.
   always_comb begin
      if (CMP_W'(limit_ff) < CMP_W'(CAPACITY)) begin
         active_limit = CMP_W'(limit_ff);
      end else begin
         active_limit = CMP_W'(CAPACITY);
      end
   end

   assign count_now = CMP_W'(count_ff);
   assign has_room  = count_now < active_limit;

   // Broadcast command. When flipped, the cells hold the list tail first:
   // a logical append becomes a push at cell 0, and the first logical match
   // is the highest-index physical match.
   always_comb begin
      ctrl           = '0;
      ctrl.any_match = pre_c[CAPACITY];
      if (accept) begin
         case (req_operation)
            OP_INSERT: begin
               ctrl.load_tail = has_room && !flipped_ff;
               ctrl.push_head = has_room && flipped_ff;
            end
            OP_DELETE: begin
               ctrl.del_fwd = !flipped_ff;
               ctrl.del_rev = flipped_ff;
            end
            default: begin
            end
         endcase
      end
   end

   assign pre_c[0]        = 1'b0;
   assign suf_c[CAPACITY] = 1'b0;

   genvar gi;
   generate
      for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
         logic [DATA_WIDTH-1:0] left_w;
         logic [DATA_WIDTH-1:0] right_w;
         logic                  valid_w;
         logic                  tail_w;

         // Cell 0 takes the new item on a push; the last cell has no successor.
         if (gi == 0) begin : g_head
            assign left_w = req_word;
         end else begin : g_mid_l
            assign left_w = word_c[gi-1];
         end
         if (gi == CAPACITY - 1) begin : g_tail
            assign right_w = word_c[gi];
         end else begin : g_mid_r
            assign right_w = word_c[gi+1];
         end

         assign valid_w = count_ff > CNT_W'(gi);
         assign tail_w  = count_ff == CNT_W'(gi);

         bol_cell u_cell (
            .clock       (clock),
            .ctrl        (ctrl),
            .entry_valid (valid_w),
            .tail_slot   (tail_w),
            .req_word    (req_word),
            .left_word   (left_w),
            .right_word  (right_w),
            .pre_in      (pre_c[gi]),
            .suf_in      (suf_c[gi+1]),
            .pre_out     (pre_c[gi+1]),
            .suf_out     (suf_c[gi]),
            .word        (word_c[gi])
         );
      end
   endgenerate

   // Next count, orientation and success for the item being taken.
   always_comb begin
      count_in   = count_ff;
      flipped_in = flipped_ff;
      ok_in      = 1'b0;
      if (accept) begin
         case (req_operation)
            OP_INSERT: begin
               if (has_room) begin
                  count_in = count_ff + CNT_W'(1);
                  ok_in    = 1'b1;
               end
            end
            OP_DELETE: begin
               if (ctrl.any_match) begin
                  count_in = count_ff - CNT_W'(1);
                  ok_in    = 1'b1;
               end
            end
            OP_REVERSE: begin
               // Only the orientation bit flips; the cells stay put.
               if (count_ff != '0) begin
                  flipped_in = !flipped_ff;
                  ok_in      = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign count_next = CMP_W'(count_in);
   assign full_in    = count_next >= active_limit;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         flipped_ff <= 1'b0;
         limit_ff   <= LIMIT_W'(CAPACITY);
         busy_ff    <= 1'b1;
         strobe_ff  <= 1'b0;
      end else begin
         count_ff   <= count_in;
         flipped_ff <= flipped_in;
         busy_ff    <= 1'b0;
         strobe_ff  <= accept;
         if (csr_write_enable) begin
            limit_ff <= csr_write_data;
         end
      end
   end

   // Hold the result payload; only the strobe marks it.
   always_ff @(posedge clock) begin
      if (accept) begin
         ok_ff      <= ok_in;
         cnt_out_ff <= count_next[4:0];
         full_ff    <= full_in;
         empty_ff   <= (count_in == '0);
      end
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_succeeded   = ok_ff;
   assign rsp_entry_count = cnt_out_ff;
   assign rsp_full_flag   = full_ff;
   assign rsp_empty_flag  = empty_ff;

   // Count never runs past the number of cells.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(count_ff) <= CMP_W'(CAPACITY))
      else $error("list count above capacity");

   // Every accepted item yields a result in the next cycle.
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> rsp_strobe)
      else $error("result strobe missing after accept");

   // A refused operation leaves the count as it was.
   a_fail_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_succeeded) |-> (count_ff == $past(count_ff)))
      else $error("count changed on a refused item");

   // Reported count matches the stored count.
   a_count_report: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_entry_count == 5'(CMP_W'(count_ff))))
      else $error("reported count differs from stored count");

endmodule
